// ===== hdl/sha1_byte_stream_hasher_core_defines.svh =====
// Assertion macros used by the checker file of the SHA-1 byte stream hasher.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef SHA1_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1BSH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1bsh: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SHA1BSH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1bsh: next-cycle check failed");

`endif

// ===== hdl/sha1bsh_pkg.sv =====
// Package of the SHA-1 byte stream hasher: opcodes, status codes, constants and types.
// It depends on nothing; every module of the block imports it.
package sha1bsh_pkg;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_DONE     = 2'd2;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [5:0]  LEN_FILL    = 6'd56;
    localparam logic [5:0]  FILL_LAST   = 6'd63;
    localparam logic [6:0]  ROUND_LAST  = 7'd79;
    localparam logic [6:0]  ROUND_EXPAND = 7'd16;
    localparam logic [2:0]  WORD_LAST   = 3'd4;
    localparam logic [63:0] LEN_WRAP    = 64'hFFFF_FFFF_FFFF_FFF8;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } work_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       step;
        logic       expand;
    } sched_ctrl_t;

endpackage

// ===== hdl/sha1_byte_stream_hasher_core.sv =====
// A data item that completes a block is followed by the 80 rounds and the fold before the next item is taken.
// A first finish pads one byte per cycle, pausing while a full block is compressed, and runs one or two
// compressions, then shows five items. A repeated finish shows its five items, an error finish its single item,
// from the next cycle, one per cycle while out_stall is low. The shared round unit does one round per cycle.
// Reset is asynchronous and clears control state and loads the initial chaining words.
module sha1_byte_stream_hasher_core import sha1bsh_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PAD  = 6'b000010,
        S_LEN  = 6'b000100,
        S_COMP = 6'b001000,
        S_FOLD = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] h_reg [5];
    logic [31:0] h_next [5];
    work_t       work_reg, work_next, work_round;
    logic [6:0]  t_reg, t_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic        finished_reg, finished_next;
    logic [1:0]  err_reg, err_next;
    logic        finishing_reg, finishing_next;
    logic        first_pad_reg, first_pad_next;
    logic [2:0]  len_idx_reg, len_idx_next;
    logic        len_done_reg, len_done_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_err_reg, out_err_next;
    logic        push_en;
    logic [7:0]  push_data;
    logic [31:0] w;
    sched_ctrl_t sched_ctrl;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign status      = out_err_reg ? err_reg : ST_OK;
    assign digest_word = out_err_reg ? 32'd0 : h_reg[out_idx_reg];
    assign word_index  = out_err_reg ? 3'd0 : out_idx_reg;
    assign last        = out_err_reg || (out_idx_reg == WORD_LAST);

    assign sched_ctrl.push      = push_en;
    assign sched_ctrl.push_byte = push_data;
    assign sched_ctrl.step      = (state_reg == S_COMP);
    assign sched_ctrl.expand    = (t_reg >= ROUND_EXPAND);

    sha1bsh_schedule u_schedule (
        .clk  (clk),
        .ctrl (sched_ctrl),
        .w    (w)
    );

    sha1bsh_round u_round (
        .cur   (work_reg),
        .w     (w),
        .round (t_reg),
        .nxt   (work_round)
    );

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        work_next      = work_reg;
        t_next         = t_reg;
        fill_next      = fill_reg;
        bitlen_next    = bitlen_reg;
        finished_next  = finished_reg;
        err_next       = err_reg;
        finishing_next = finishing_reg;
        first_pad_next = first_pad_reg;
        len_idx_next   = len_idx_reg;
        len_done_next  = len_done_reg;
        out_idx_next   = out_idx_reg;
        out_err_next   = out_err_reg;
        push_en        = 1'b0;
        push_data      = data_byte;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (opcode)
                        OP_START:
                        begin
                            h_next        = H_INIT;
                            fill_next     = 6'd0;
                            bitlen_next   = 64'd0;
                            finished_next = 1'b0;
                            err_next      = ST_OK;
                        end
                        OP_DATA:
                        begin
                            if (finished_reg)
                            begin
                                err_next = ST_DONE;
                            end
                            else if (err_reg == ST_OK)
                            begin
                                bitlen_next = bitlen_reg + 64'd8;
                                if (bitlen_reg == LEN_WRAP)
                                begin
                                    err_next = ST_OVERFLOW;
                                end
                                push_en   = 1'b1;
                                push_data = data_byte;
                            end
                        end
                        OP_FINISH:
                        begin
                            out_idx_next = 3'd0;
                            if (err_reg != ST_OK)
                            begin
                                out_err_next = 1'b1;
                                state_next   = S_OUT;
                            end
                            else if (finished_reg)
                            begin
                                out_err_next = 1'b0;
                                state_next   = S_OUT;
                            end
                            else
                            begin
                                finishing_next = 1'b1;
                                first_pad_next = 1'b1;
                                len_idx_next   = 3'd0;
                                len_done_next  = 1'b0;
                                state_next     = S_PAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PAD:
            begin
                if (first_pad_reg)
                begin
                    first_pad_next = 1'b0;
                    push_en        = 1'b1;
                    push_data      = PAD_BYTE;
                end
                else if (fill_reg == LEN_FILL)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    push_en   = 1'b1;
                    push_data = 8'd0;
                end
            end
            S_LEN:
            begin
                push_en      = 1'b1;
                push_data    = bitlen_reg[{~len_idx_reg, 3'b000} +: 8];
                len_idx_next = len_idx_reg + 3'd1;
                if (len_idx_reg == 3'd7)
                begin
                    len_done_next = 1'b1;
                end
            end
            S_COMP:
            begin
                work_next = work_round;
                t_next    = t_reg + 7'd1;
                if (t_reg == ROUND_LAST)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                h_next[0] = h_reg[0] + work_reg.a;
                h_next[1] = h_reg[1] + work_reg.b;
                h_next[2] = h_reg[2] + work_reg.c;
                h_next[3] = h_reg[3] + work_reg.d;
                h_next[4] = h_reg[4] + work_reg.e;
                if (!finishing_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (len_done_reg)
                begin
                    finishing_next = 1'b0;
                    len_done_next  = 1'b0;
                    bitlen_next    = 64'd0;
                    finished_next  = 1'b1;
                    out_idx_next   = 3'd0;
                    out_err_next   = 1'b0;
                    state_next     = S_OUT;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en)
        begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg == FILL_LAST)
            begin
                state_next  = S_COMP;
                t_next      = 7'd0;
                work_next.a = h_reg[0];
                work_next.b = h_reg[1];
                work_next.c = h_reg[2];
                work_next.d = h_reg[3];
                work_next.e = h_reg[4];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            h_reg         <= H_INIT;
            t_reg         <= 7'd0;
            fill_reg      <= 6'd0;
            bitlen_reg    <= 64'd0;
            finished_reg  <= 1'b0;
            err_reg       <= ST_OK;
            finishing_reg <= 1'b0;
            first_pad_reg <= 1'b0;
            len_idx_reg   <= 3'd0;
            len_done_reg  <= 1'b0;
            out_idx_reg   <= 3'd0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            t_reg         <= t_next;
            fill_reg      <= fill_next;
            bitlen_reg    <= bitlen_next;
            finished_reg  <= finished_next;
            err_reg       <= err_next;
            finishing_reg <= finishing_next;
            first_pad_reg <= first_pad_next;
            len_idx_reg   <= len_idx_next;
            len_done_reg  <= len_done_next;
            out_idx_reg   <= out_idx_next;
            out_err_reg   <= out_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

endmodule

// ===== hdl/sha1bsh_round.sv =====
// One SHA-1 round: the shared adder chain and round function used for all 80 rounds.
// It depends on sha1bsh_pkg for the working-variable type and the round constants.
module sha1bsh_round import sha1bsh_pkg::*; (
    input  work_t       cur,
    input  logic [31:0] w,
    input  logic [6:0]  round,
    output work_t       nxt
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] temp;

    always_comb
    begin
        if (round < 7'd20)
        begin
            f = (cur.b & cur.c) | (~cur.b & cur.d);
            k = K_0;
        end
        else if (round < 7'd40)
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_1;
        end
        else if (round < 7'd60)
        begin
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = K_2;
        end
        else
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_3;
        end
    end

    assign temp  = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
    assign nxt.a = temp;
    assign nxt.b = cur.a;
    assign nxt.c = {cur.b[1:0], cur.b[31:2]};
    assign nxt.d = cur.c;
    assign nxt.e = cur.d;

endmodule

// ===== hdl/sha1bsh_schedule.sv =====
// Message block and rolling schedule window as one 16-word shift line.
// It depends on sha1bsh_pkg for the control struct.
module sha1bsh_schedule import sha1bsh_pkg::*; (
    input  logic        clk,
    input  sched_ctrl_t ctrl,
    output logic [31:0] w
);

    logic [31:0] win_reg [16];
    logic [31:0] mix;

    assign mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w   = ctrl.expand ? {mix[30:0], mix[31]} : win_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], ctrl.push_byte};
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w;
        end
    end

endmodule

// ===== hdl/sha1bsh_checker.sv =====
// Port-level checker of the SHA-1 byte stream hasher and the bind that attaches it.
// It depends on sha1bsh_pkg and on the assertion macros of the defines header.
`include "sha1_byte_stream_hasher_core_defines.svh"

module sha1bsh_checker import sha1bsh_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  opcode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last
);

    logic       in_take;
    logic       out_take;
    logic       err_clean;
    logic [2:0] idx_step;

    assign in_take   = in_valid && !in_stall && (opcode == OP_FINISH);
    assign out_take  = out_valid && !out_stall;
    assign err_clean = last && (digest_word == 32'd0) && (word_index == 3'd0);
    assign idx_step  = word_index + 3'd1;

    // No new item is taken while results of a finish are still being delivered.
    `SHA1BSH_ASSERT_NOW(a_busy_while_output, out_valid, in_stall)

    // Digest words follow one another in order until the one marked last.
    `SHA1BSH_ASSERT_NEXT(a_word_order, out_take && !last, out_valid && (word_index == $past(idx_step)))

    // An error item stands alone and carries no digest.
    `SHA1BSH_ASSERT_NOW(a_error_alone, out_valid && (status != ST_OK), err_clean)

    // A finish taken in idle is answered by an item in the next cycle or later, never at once.
    `SHA1BSH_ASSERT_NOW(a_no_output_on_take, in_take, !out_valid)

endmodule

bind sha1_byte_stream_hasher_core sha1bsh_checker u_sha1bsh_checker (.*);
